// File: hw/rtl/sit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sit_pkg
// Shared widths and word types of the square spiral index to coordinate block.
// ----------------------------------------------------------------------------
package sit_pkg;

   localparam int SIDE_BITS = 16;
   localparam int POS_BITS  = 2 * SIDE_BITS;
   localparam int REM_BITS  = POS_BITS + 1;
   localparam int D_BITS    = SIDE_BITS + 3;

   typedef struct packed {
      logic [SIDE_BITS-1:0] side_length;
      logic [POS_BITS-1:0]  position;
   } req_word_type;

   typedef struct packed {
      logic [SIDE_BITS-1:0] line_number;
      logic [SIDE_BITS-1:0] column_number;
      logic                 valid_res;
   } rsp_word_type;

   typedef struct packed {
      logic                 ok;
      logic [SIDE_BITS-1:0] side;
      logic [POS_BITS-1:0]  pos;
   } item_type;

endpackage
`default_nettype wire

// File: hw/rtl/sit_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sit_front
// Registers the request word, squares the side and screens the request.
// ----------------------------------------------------------------------------
module sit_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire sit_pkg::req_word_type in_word,
   output logic                       out_valid,
   output sit_pkg::item_type          out_item
);

   logic                          v1_ff;
   sit_pkg::req_word_type         word1_ff;
   logic [sit_pkg::POS_BITS-1:0]  side_sq1_ff;
   logic [sit_pkg::POS_BITS-1:0]  side_sq1_in;
   logic                          v2_ff;
   sit_pkg::item_type             item2_ff;
   sit_pkg::item_type             item2_in;

   assign side_sq1_in = sit_pkg::POS_BITS'(in_word.side_length) *
                        sit_pkg::POS_BITS'(in_word.side_length);

   always_comb begin
      item2_in.side = word1_ff.side_length;
      item2_in.pos  = word1_ff.position;
      item2_in.ok   = word1_ff.side_length[0] && (word1_ff.position != '0) &&
                      (word1_ff.position <= side_sq1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word1_ff    <= in_word;
         side_sq1_ff <= side_sq1_in;
         item2_ff    <= item2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = item2_ff;

endmodule
`default_nettype wire

// File: hw/rtl/sit_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sit_isqrt
// Pipelined exact floor square root of the position, one root bit per stage.
// ----------------------------------------------------------------------------
module sit_isqrt (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire sit_pkg::item_type      in_item,
   output logic                        out_valid,
   output sit_pkg::item_type           out_item,
   output logic [sit_pkg::SIDE_BITS-1:0] out_root
);

   localparam int STAGES = sit_pkg::SIDE_BITS;

   logic                          v_ff    [STAGES];
   sit_pkg::item_type             item_ff [STAGES];
   logic [sit_pkg::REM_BITS-1:0]  rem_ff  [STAGES];
   logic [sit_pkg::SIDE_BITS-1:0] root_ff [STAGES];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      localparam int K = STAGES - 1 - j;

      logic                          v_cur;
      sit_pkg::item_type             item_cur;
      logic [sit_pkg::REM_BITS-1:0]  rem_cur;
      logic [sit_pkg::SIDE_BITS-1:0] root_cur;
      logic [sit_pkg::REM_BITS-1:0]  trial;
      logic                          take;
      logic [sit_pkg::REM_BITS-1:0]  rem_in;
      logic [sit_pkg::SIDE_BITS-1:0] root_in;

      if (j == 0) begin : g_first
         assign v_cur    = in_valid;
         assign item_cur = in_item;
         assign rem_cur  = sit_pkg::REM_BITS'(in_item.pos);
         assign root_cur = '0;
      end else begin : g_next
         assign v_cur    = v_ff[j-1];
         assign item_cur = item_ff[j-1];
         assign rem_cur  = rem_ff[j-1];
         assign root_cur = root_ff[j-1];
      end

      // (root + 2^K)^2 - root^2, with the root clear below bit K.
      always_comb begin
         trial   = (sit_pkg::REM_BITS'(root_cur) << (K + 1)) |
                   (sit_pkg::REM_BITS'(1) << (2 * K));
         take    = (rem_cur >= trial);
         rem_in  = take ? (rem_cur - trial) : rem_cur;
         root_in = root_cur;
         root_in[K] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (advance) begin
            v_ff[j] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            item_ff[j] <= item_cur;
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_item  = item_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];

endmodule
`default_nettype wire

// File: hw/rtl/sit_place.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sit_place
// Rounds the root down to odd and turns it into a ring segment and the
// cell's line and column, ending in the response register.
// ----------------------------------------------------------------------------
module sit_place (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     in_valid,
   input  wire sit_pkg::item_type        in_item,
   input  wire logic [sit_pkg::SIDE_BITS-1:0] in_root,
   output logic                          out_valid,
   output sit_pkg::rsp_word_type         out_word
);

   localparam int SB = sit_pkg::SIDE_BITS;
   localparam int DB = sit_pkg::D_BITS;

   // First stage: odd root and its square.
   logic                         v1_ff;
   sit_pkg::item_type            item1_ff;
   logic [SB-1:0]                n1_ff;
   logic [SB-1:0]                n1_in;
   logic [sit_pkg::POS_BITS-1:0] nsq1_ff;
   logic [sit_pkg::POS_BITS-1:0] nsq1_in;

   // Second stage: offset into the ring and segment bounds.
   logic          v2_ff;
   logic          ok2_ff;
   logic [DB-1:0] d2_ff, d2_in;
   logic [DB-1:0] t1_2_ff, t1_2_in;
   logic [DB-1:0] t2_2_ff, t2_2_in;
   logic [DB-1:0] t3_2_ff, t3_2_in;
   logic [DB-1:0] t4_2_ff, t4_2_in;
   logic [SB-1:0] lo2_ff, lo2_in;
   logic [SB-1:0] hi2_ff, hi2_in;
   logic [sit_pkg::POS_BITS-1:0] diff_full;

   // Response register.
   logic                  v3_ff;
   sit_pkg::rsp_word_type word3_ff;
   sit_pkg::rsp_word_type word3_in;
   logic [DB-1:0]         diff_a, diff_b, diff_c;

   always_comb begin
      n1_in   = in_root[0] ? in_root : (in_root - SB'(1));
      nsq1_in = sit_pkg::POS_BITS'(n1_in) * sit_pkg::POS_BITS'(n1_in);
   end

   always_comb begin
      diff_full = item1_ff.pos - nsq1_ff;
      d2_in     = diff_full[DB-1:0];
      t1_2_in   = DB'(n1_ff) + DB'(1);
      t2_2_in   = t1_2_in << 1;
      t3_2_in   = t2_2_in + t1_2_in;
      t4_2_in   = t1_2_in << 2;
      lo2_in    = (item1_ff.side >> 1) - (n1_ff >> 1);
      hi2_in    = (item1_ff.side >> 1) + (n1_ff >> 1) + SB'(2);
   end

   always_comb begin
      diff_a = t2_2_ff - d2_ff;
      diff_b = d2_ff - t2_2_ff;
      diff_c = t4_2_ff - d2_ff;
      word3_in.valid_res = ok2_ff;
      priority if (!ok2_ff) begin
         word3_in.line_number   = '0;
         word3_in.column_number = '0;
      end else if (d2_ff == '0) begin
         word3_in.line_number   = hi2_ff - SB'(1);
         word3_in.column_number = hi2_ff - SB'(1);
      end else if (d2_ff <= t1_2_ff) begin
         word3_in.line_number   = hi2_ff;
         word3_in.column_number = hi2_ff - d2_ff[SB-1:0];
      end else if (d2_ff <= t2_2_ff) begin
         word3_in.line_number   = lo2_ff + diff_a[SB-1:0];
         word3_in.column_number = lo2_ff;
      end else if (d2_ff <= t3_2_ff) begin
         word3_in.line_number   = lo2_ff;
         word3_in.column_number = lo2_ff + diff_b[SB-1:0];
      end else begin
         word3_in.line_number   = hi2_ff - diff_c[SB-1:0];
         word3_in.column_number = hi2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item1_ff <= in_item;
         n1_ff    <= n1_in;
         nsq1_ff  <= nsq1_in;
         ok2_ff   <= item1_ff.ok;
         d2_ff    <= d2_in;
         t1_2_ff  <= t1_2_in;
         t2_2_ff  <= t2_2_in;
         t3_2_ff  <= t3_2_in;
         t4_2_ff  <= t4_2_in;
         lo2_ff   <= lo2_in;
         hi2_ff   <= hi2_in;
         word3_ff <= word3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_word  = word3_ff;

endmodule
`default_nettype wire

// File: hw/rtl/spiral_index_to_coordinate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spiral_index_to_coordinate
// Maps a position along a square spiral to the line and column of its cell.
// ----------------------------------------------------------------------------
// Each request word carries an odd side length and a one-based position along
// the spiral from the grid's center; the response word gives the one-based
// line and column of that cell, or valid_res low with zero coordinates for an
// even side, position zero or a position past side squared. The block takes
// one word every cycle unless a response waits under stall, and passes it
// through two screening stages, sixteen square root stages that each settle
// one root bit, and three placement stages ending in the response register.
// The whole pipeline holds while a response waits under stall, so request
// stall follows response stall whenever a response is pending.
module spiral_index_to_coordinate (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sit_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sit_pkg::rsp_word_type      rsp_word
);

   logic                          advance;
   logic                          front_valid;
   sit_pkg::item_type             front_item;
   logic                          root_valid;
   sit_pkg::item_type             root_item;
   logic [sit_pkg::SIDE_BITS-1:0] root_value;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   sit_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   sit_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .out_valid (root_valid),
      .out_item  (root_item),
      .out_root  (root_value)
   );

   sit_place u_place (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (root_valid),
      .in_item   (root_item),
      .in_root   (root_value),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

endmodule
`default_nettype wire

// File: hw/rtl/sit_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sit_checker
// Port level checks of the spiral index to coordinate block.
// ----------------------------------------------------------------------------
module sit_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire sit_pkg::rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("Stalled response word changed.");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.valid_res |->
         rsp_word.line_number == '0 && rsp_word.column_number == '0)
      else $error("Rejected request gave nonzero coordinates.");

   a_valid_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.valid_res |->
         rsp_word.line_number != '0 && rsp_word.column_number != '0)
      else $error("Accepted request gave a zero coordinate.");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Request word taken while the response was blocked.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response valid right after reset.");

endmodule

bind spiral_index_to_coordinate sit_checker u_checker (.*);
`default_nettype wire
